### src/imhq_pkg.sv
// ---------------------------------------------------------------------------
// imhq_pkg: shared types and constants for the indexed min-heap queue
// Word formats, status codes, mode codes and the back-end state type.
// ---------------------------------------------------------------------------
package imhq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 32;
    localparam int ID_BITS   = 10;
    localparam int SLOT_BITS = 11;      // slots 1..CAPACITY
    localparam int CNT_BITS  = 11;
    localparam int ID_COUNT  = 1024;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DELMIN   = 2'd1,
        MODE_DECREASE = 2'd2,
        MODE_NOP      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_ABSENT = 3'd4,
        ST_LARGER = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]          mode;
        logic [ID_BITS-1:0]  item_id;
        logic [KEY_BITS-1:0] new_key;
    } t_in_word;

    typedef struct packed {
        logic [2:0]          status;
        logic [ID_BITS-1:0]  removed_id;
        logic [KEY_BITS-1:0] removed_key;
        logic [CNT_BITS-1:0] queue_size;
        logic [ID_BITS-1:0]  top_id;
        logic [KEY_BITS-1:0] top_key;
        logic                is_empty;
    } t_out_word;

    // queue entry from front to back
    typedef struct packed {
        t_mode               mode;
        logic [ID_BITS-1:0]  item_id;
        logic [KEY_BITS-1:0] new_key;
    } t_cmd;

    localparam int QDEPTH = 2;

    typedef enum logic [3:0] {
        S_CLEAR,    // presence-bit clearing pass after reset
        S_IDLE,
        S_CHECK,    // read presence / position / root
        S_CHECK2,   // check capacity / presence / bounds by mode
        S_UP_RD,    // read parent
        S_UP_CMP,
        S_DN_RD,    // read children
        S_DN_CMP,
        S_DEL_RD,   // read slot at position
        S_DEL_WR,
        S_TOP_RD,
        S_RESULT
    } t_state;

endpackage

### src/imhq_front.sv
// ---------------------------------------------------------------------------
// imhq_front: command intake queue
// Takes command words and holds them until the back end pulls one.
// ---------------------------------------------------------------------------
module imhq_front import imhq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_word,
    output logic     o_full,
    output logic     o_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);
    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.mode    = t_mode'(i_word.mode);
        w_cmd.item_id = i_word.item_id;
        w_cmd.new_key = i_word.new_key;
    end

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("count out of range");
endmodule

### src/imhq_back.sv
// ---------------------------------------------------------------------------
// imhq_back: heap engine
// Runs insert, delete-min and decrease-key over slot and position memories.
// ---------------------------------------------------------------------------
module imhq_back import imhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_idle,
    output logic      o_strobe,
    output t_out_word o_word
);
    // slot memory: id and key, two write ports and two registered read ports
    logic [ID_BITS+KEY_BITS-1:0] m_slot [CAPACITY+1];
    logic [SLOT_BITS-1:0]        m_pos  [ID_COUNT];
    logic                        m_pres [ID_COUNT];

    t_state r_st, n_st;
    t_cmd   r_cmd;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [SLOT_BITS-1:0] r_k;
    logic [2:0]           r_status;
    logic [ID_BITS-1:0]   r_rem_id;
    logic [KEY_BITS-1:0]  r_rem_key;
    logic [ID_BITS-1:0]   r_clr;    // clearing pass address

    // read ports
    logic [SLOT_BITS-1:0] w_ra, w_rb;
    logic [ID_BITS+KEY_BITS-1:0] r_da, r_db;
    logic [ID_BITS-1:0]   w_pra;
    logic [SLOT_BITS-1:0] r_pos;
    logic                 r_pbit;
    // write ports
    logic w_swe_a, w_swe_b;
    logic [SLOT_BITS-1:0] w_swa_a, w_swa_b;
    logic [ID_BITS+KEY_BITS-1:0] w_swd_a, w_swd_b;
    logic w_pwe_a, w_pwe_b;
    logic [ID_BITS-1:0] w_pwa_a, w_pwa_b;
    logic [SLOT_BITS-1:0] w_pwd_a, w_pwd_b;
    logic w_bwe, w_bwd;
    logic [ID_BITS-1:0] w_bwa;

    // sift register copies
    logic [ID_BITS-1:0]   r_id;   // item being moved
    logic [KEY_BITS-1:0]  r_key;

    logic [ID_BITS-1:0]  w_aid, w_bid;
    logic [KEY_BITS-1:0] w_akey, w_bkey;
    assign w_aid  = r_da[ID_BITS+KEY_BITS-1:KEY_BITS];
    assign w_akey = r_da[KEY_BITS-1:0];
    assign w_bid  = r_db[ID_BITS+KEY_BITS-1:KEY_BITS];
    assign w_bkey = r_db[KEY_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_da   <= m_slot[w_ra];
        r_db   <= m_slot[w_rb];
        r_pos  <= m_pos[w_pra];
        if (w_swe_a) m_slot[w_swa_a] <= w_swd_a;
        if (w_swe_b) m_slot[w_swa_b] <= w_swd_b;
        if (w_pwe_a) m_pos[w_pwa_a] <= w_pwd_a;
        if (w_pwe_b) m_pos[w_pwa_b] <= w_pwd_b;
    end

    // presence bits: one write and one registered read per cycle,
    // cleared by a pass over all ids after reset
    always_ff @(posedge i_clk) begin
        if (w_bwe) m_pres[w_bwa] <= w_bwd;
        r_pbit <= m_pres[w_pra];
    end

    // child choice for sift-down
    logic [SLOT_BITS:0] w_c2;
    logic               w_has_r, w_take_r;
    logic [SLOT_BITS-1:0] w_c;
    logic [ID_BITS-1:0]   w_cid;
    logic [KEY_BITS-1:0]  w_ckey;
    assign w_c2     = {r_k, 1'b0};
    assign w_has_r  = (w_c2 < {1'b0, r_cnt});
    assign w_take_r = w_has_r && (w_akey > w_bkey);
    assign w_c      = w_take_r ? (w_c2[SLOT_BITS-1:0] + 1'b1) : w_c2[SLOT_BITS-1:0];
    assign w_cid    = w_take_r ? w_bid : w_aid;
    assign w_ckey   = w_take_r ? w_bkey : w_akey;

    // next-state values and output registers
    t_cmd   n_cmd;
    logic [CNT_BITS-1:0]  n_cnt;
    logic [SLOT_BITS-1:0] n_k;
    logic [2:0]           n_status;
    logic [ID_BITS-1:0]   n_rem_id, n_id;
    logic [KEY_BITS-1:0]  n_rem_key, n_key;
    logic [ID_BITS-1:0]   n_clr;
    t_out_word r_out, n_out;
    logic r_stb, n_stb;

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_cnt = r_cnt; n_k = r_k;
        n_status = r_status; n_rem_id = r_rem_id; n_rem_key = r_rem_key;
        n_id = r_id; n_key = r_key; n_out = r_out; n_stb = 1'b0;
        n_clr = r_clr;
        o_pop = 1'b0;
        w_ra = '0; w_rb = '0; w_pra = r_cmd.item_id;
        w_swe_a = 1'b0; w_swa_a = '0; w_swd_a = '0;
        w_swe_b = 1'b0; w_swa_b = '0; w_swd_b = '0;
        w_pwe_a = 1'b0; w_pwa_a = '0; w_pwd_a = '0;
        w_pwe_b = 1'b0; w_pwa_b = '0; w_pwd_b = '0;
        w_bwe = 1'b0; w_bwa = r_cmd.item_id; w_bwd = 1'b0;
        case (r_st)
            S_CLEAR: begin
                w_bwe = 1'b1; w_bwa = r_clr; w_bwd = 1'b0;
                n_clr = r_clr + 1'b1;
                if (r_clr == ID_BITS'(ID_COUNT - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_status = ST_OK; n_rem_id = '0; n_rem_key = '0;
                    n_st = S_CHECK;
                end
            end
            S_CHECK: begin
                // presence and position of the id; root and last slot
                w_pra = r_cmd.item_id;
                w_ra  = SLOT_BITS'(1);
                w_rb  = r_cnt[SLOT_BITS-1:0];
                n_st  = S_CHECK2;
            end
            S_CHECK2: begin
                case (r_cmd.mode)
                    MODE_INSERT: begin
                        if (r_cnt >= CNT_BITS'(CAPACITY)) begin
                            n_status = ST_FULL; n_st = S_TOP_RD;
                        end else if (r_pbit) begin
                            n_status = ST_DUP; n_st = S_TOP_RD;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                            n_k   = n_cnt[SLOT_BITS-1:0];
                            n_id  = r_cmd.item_id; n_key = r_cmd.new_key;
                            w_swe_a = 1'b1; w_swa_a = n_k;
                            w_swd_a = {r_cmd.item_id, r_cmd.new_key};
                            w_pwe_a = 1'b1; w_pwa_a = r_cmd.item_id; w_pwd_a = n_k;
                            w_bwe = 1'b1; w_bwd = 1'b1;
                            n_st = S_UP_RD;
                        end
                    end
                    MODE_DELMIN: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY; n_st = S_TOP_RD;
                        end else begin
                            n_rem_id = w_aid; n_rem_key = w_akey;
                            w_bwe = 1'b1; w_bwa = w_aid; w_bwd = 1'b0;
                            // last item moves to root then sifts down
                            n_id = w_bid; n_key = w_bkey;
                            n_cnt = r_cnt - 1'b1;
                            n_k = SLOT_BITS'(1);
                            w_swe_a = 1'b1; w_swa_a = SLOT_BITS'(1); w_swd_a = r_db;
                            w_pwe_a = 1'b1; w_pwa_a = w_bid; w_pwd_a = SLOT_BITS'(1);
                            n_st = S_DN_RD;
                        end
                    end
                    MODE_DECREASE: begin
                        if (!r_pbit || r_pos == '0 ||
                            {1'b0, r_pos} > {1'b0, r_cnt}) begin
                            n_status = ST_ABSENT; n_st = S_TOP_RD;
                        end else begin
                            n_k = r_pos; n_st = S_DEL_RD;
                        end
                    end
                    default: n_st = S_TOP_RD;
                endcase
            end
            S_DEL_RD: begin
                w_ra = r_k;
                n_st = S_DEL_WR;
            end
            S_DEL_WR: begin
                if (r_cmd.new_key > w_akey) begin
                    n_status = ST_LARGER; n_st = S_TOP_RD;
                end else begin
                    n_id = w_aid; n_key = r_cmd.new_key;
                    w_swe_a = 1'b1; w_swa_a = r_k; w_swd_a = {w_aid, r_cmd.new_key};
                    n_st = S_UP_RD;
                end
            end
            S_UP_RD: begin
                w_ra = r_k >> 1;
                n_st = (r_k > SLOT_BITS'(1)) ? S_UP_CMP : S_TOP_RD;
            end
            S_UP_CMP: begin
                if (w_akey > r_key) begin
                    // parent down to k, item up to k/2
                    w_swe_a = 1'b1; w_swa_a = r_k; w_swd_a = r_da;
                    w_pwe_a = 1'b1; w_pwa_a = w_aid; w_pwd_a = r_k;
                    w_swe_b = 1'b1; w_swa_b = r_k >> 1; w_swd_b = {r_id, r_key};
                    w_pwe_b = 1'b1; w_pwa_b = r_id; w_pwd_b = r_k >> 1;
                    n_k = r_k >> 1;
                    n_st = S_UP_RD;
                end else begin
                    n_st = S_TOP_RD;
                end
            end
            S_DN_RD: begin
                w_ra = w_c2[SLOT_BITS-1:0];
                w_rb = w_c2[SLOT_BITS-1:0] + 1'b1;
                n_st = (w_c2 <= {1'b0, r_cnt}) ? S_DN_CMP : S_TOP_RD;
            end
            S_DN_CMP: begin
                if (r_key > w_ckey) begin
                    w_swe_a = 1'b1; w_swa_a = r_k; w_swd_a = {w_cid, w_ckey};
                    w_pwe_a = 1'b1; w_pwa_a = w_cid; w_pwd_a = r_k;
                    w_swe_b = 1'b1; w_swa_b = w_c; w_swd_b = {r_id, r_key};
                    w_pwe_b = 1'b1; w_pwa_b = r_id; w_pwd_b = w_c;
                    n_k = w_c;
                    n_st = S_DN_RD;
                end else begin
                    n_st = S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                w_ra = SLOT_BITS'(1);
                n_st = S_RESULT;
            end
            S_RESULT: begin
                n_out.status      = r_status;
                n_out.removed_id  = r_rem_id;
                n_out.removed_key = r_rem_key;
                n_out.queue_size  = r_cnt;
                n_out.is_empty    = (r_cnt == '0);
                n_out.top_id      = (r_cnt == '0) ? '0 : w_aid;
                n_out.top_key     = (r_cnt == '0) ? '0 : w_akey;
                n_stb = 1'b1;
                n_st  = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_k <= n_k; r_status <= n_status;
        r_rem_id <= n_rem_id; r_rem_key <= n_rem_key;
        r_id <= n_id; r_key <= n_key; r_out <= n_out;
        if (!i_rst_n) begin
            r_st  <= S_CLEAR;
            r_clr <= '0;
            r_cnt <= '0;
            r_stb <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_cnt <= n_cnt;
            r_stb <= n_stb;
        end
    end

    assign o_strobe = r_stb;
    assign o_word   = r_out;
    assign o_idle   = (r_st == S_IDLE);

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(CAPACITY)) else $error("count above capacity");
    a_strobe_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_RESULT |=> r_stb) else $error("missing result strobe");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == S_IDLE) else $error("pop outside idle");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |=> $stable(r_cnt)) else $error("count changed in idle");
endmodule

### src/indexed_min_heap_queue.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap priority queue
// Insert, delete-min, decrease-key and no-op on (id, key) words, one result each.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               word
//  command   in         start / busy            t_in_word  i_cmd
//  result    out        o_done (1 cycle strobe) t_out_word o_result
//
//  Steps: pop, check, reads, then per sift level a parent or child
//  read, then compare and swap; then top read and result register.
//  Reset: synchronous, active low; clears count and control, then a
//  pass over all 1024 ids clears the presence bits before the first word runs.
//  Stalls: busy is high while the two-word command queue is full; during
//  the clearing pass the queue still takes words. The receiver cannot stall results; each is
//  shown for one cycle on o_done.
// ---------------------------------------------------------------------------
module indexed_min_heap_queue import imhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_done,
    output t_out_word o_result
);
    logic w_push, w_full, w_valid, w_pop, w_idle;
    t_cmd w_cmd;

    assign busy   = w_full;
    assign w_push = start && !busy;

    // front: command intake queue
    imhq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (i_cmd),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_cmd   (w_cmd),
        .i_pop   (w_pop)
    );

    // back: heap engine and result register
    imhq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_cmd    (w_cmd),
        .o_pop    (w_pop),
        .o_idle   (w_idle),
        .o_strobe (o_done),
        .o_word   (o_result)
    );

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid && w_idle) else $error("pop without word");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_valid) else $error("busy with empty queue");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
endmodule
